// ===== src/hsfb_pkg.sv =====
package hsfb_pkg;

  typedef logic [7:0] byte_t;

  // Register map, by place in the list (byte address is four times this)
  localparam logic REG_VOLUME   = 1'b0;
  localparam logic REG_INDEX_EN = 1'b1;

  localparam byte_t SYNC_RAW      = 8'hFD;
  localparam byte_t MAIN_SEC_ODD  = 8'd4;
  localparam byte_t MAIN_SEC_EVEN = 8'd9;

  function automatic byte_t rev8(input byte_t v);
    byte_t r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  // XOR the byte in, then rotate left by one
  function automatic byte_t sum_step(input byte_t s, input byte_t b);
    byte_t x;
    x = s ^ b;
    return {x[6:0], x[7]};
  endfunction

endpackage

// ===== src/hard_sector_frame_builder_top.sv =====
// Hard-sectored floppy sector framer. Takes the data bytes of a sector one word at a time and
// sends out the track byte stream, one byte per cycle from a single byte sequencer while
// out_tready does not stall it. The first data word of a sector brings out the preamble (lead
// gap, hole gap with the hole/index flags on its first byte, sync, volume, cylinder, sector,
// header checksum, second lead gap, sync) ahead of the data byte. The last data word of a
// sector adds the data checksum and a zero pad byte. Every other data word brings out only its
// data byte. The output register lets the next word be taken while the last byte of the
// previous word waits to be taken.
module hard_sector_frame_builder_top
  import hsfb_pkg::*;
#(
  parameter int SECTOR_BYTES = 256,
  parameter int LEAD_GAP     = 17,
  parameter int HOLE_GAP     = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [15:8] cylinder_number, [23:16] sector_number
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] code_byte
  output logic [1:0]  out_tuser,  // [0] sector_hole, [1] main_index
  output logic        out_tlast,  // last_of_run
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int P_HOLE  = LEAD_GAP;
  localparam int P_SYNC1 = LEAD_GAP + HOLE_GAP;
  localparam int P_VOL   = P_SYNC1 + 1;
  localparam int P_CYL   = P_SYNC1 + 2;
  localparam int P_SEC   = P_SYNC1 + 3;
  localparam int P_HSUM  = P_SYNC1 + 4;
  localparam int P_SYNC2 = P_HSUM + LEAD_GAP + 1;
  localparam int P_DATA  = P_SYNC2 + 1;
  localparam int P_SUM   = P_DATA + 1;
  localparam int P_PAD   = P_DATA + 2;
  localparam int PW      = $clog2(P_PAD + 1);
  localparam int CW      = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;

  // configuration registers
  byte_t volume_r;
  logic  index_en_r;
  logic  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r   <= '0;
      index_en_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_VOLUME:   volume_r   <= cfg_pwdata[7:0];
        REG_INDEX_EN: index_en_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[2])
      REG_VOLUME:   cfg_prdata[7:0] = volume_r;
      REG_INDEX_EN: cfg_prdata[0]   = index_en_r;
      default: ;
    endcase
  end

  // sector state
  logic [CW-1:0] cnt_r;
  byte_t         sum_r;

  // word in progress
  logic          cur_valid_r;
  logic [PW-1:0] pos_r;
  logic          last_r;
  byte_t         data_r, cyl_r, sec_r, hsum_r, dsum_r;
  logic          main_hit_r;

  // output register
  logic          out_valid_r;
  byte_t         out_byte_r;
  logic          out_hole_r, out_main_r, out_last_r;

  byte_t         in_data, in_cyl, in_sec;
  logic          in_acc, first, last;
  byte_t         dsum_nxt, hsum_nxt;
  logic [PW-1:0] end_pos;
  logic          emit, done;
  byte_t         code_nxt;
  logic          hole_nxt;

  assign in_data = in_tdata[7:0];
  assign in_cyl  = in_tdata[15:8];
  assign in_sec  = in_tdata[23:16];

  assign first    = (cnt_r == '0);
  assign last     = (cnt_r == CW'(SECTOR_BYTES - 1));
  assign dsum_nxt = sum_step(first ? 8'h00 : sum_r, in_data);
  assign hsum_nxt = sum_step(sum_step(sum_step(8'h00, volume_r), in_cyl), in_sec);

  assign end_pos   = last_r ? PW'(P_PAD) : PW'(P_DATA);
  assign emit      = cur_valid_r && (!out_valid_r || out_tready);
  assign done      = emit && (pos_r == end_pos);
  assign in_tready = !cur_valid_r || done;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_r       <= '0;
      cur_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r       <= last ? '0 : cnt_r + CW'(1);
        sum_r       <= last ? 8'h00 : dsum_nxt;
        cur_valid_r <= 1'b1;
      end else if (done) begin
        cur_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      // preamble only on the first word of a sector
      pos_r      <= first ? '0 : PW'(P_DATA);
      last_r     <= last;
      data_r     <= in_data;
      cyl_r      <= in_cyl;
      sec_r      <= in_sec;
      hsum_r     <= hsum_nxt;
      dsum_r     <= dsum_nxt;
      main_hit_r <= in_cyl[0] ? (in_sec == MAIN_SEC_ODD) : (in_sec == MAIN_SEC_EVEN);
    end else if (emit) begin
      pos_r <= pos_r + PW'(1);
    end
  end

  // byte at the current position
  always_comb begin
    code_nxt = 8'h00;
    if (pos_r == PW'(P_SYNC1) || pos_r == PW'(P_SYNC2)) begin
      code_nxt = rev8(SYNC_RAW);
    end else if (pos_r == PW'(P_VOL)) begin
      code_nxt = rev8(volume_r);
    end else if (pos_r == PW'(P_CYL)) begin
      code_nxt = rev8(cyl_r);
    end else if (pos_r == PW'(P_SEC)) begin
      code_nxt = rev8(sec_r);
    end else if (pos_r == PW'(P_HSUM)) begin
      code_nxt = rev8(hsum_r);
    end else if (pos_r == PW'(P_DATA)) begin
      code_nxt = rev8(data_r);
    end else if (pos_r == PW'(P_SUM)) begin
      code_nxt = rev8(dsum_r);
    end
  end

  assign hole_nxt = (pos_r == PW'(P_HOLE)) && index_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= code_nxt;
      out_hole_r <= hole_nxt;
      out_main_r <= hole_nxt && main_hit_r;
      out_last_r <= (pos_r == end_pos);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_main_r, out_hole_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> pos_r <= end_pos)
    else $error("sequencer ran past the end of its word");

  a_main_needs_hole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_main_r |-> out_hole_r)
    else $error("main index without sector hole");

  a_hole_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    emit && hole_nxt |-> index_en_r)
    else $error("sector hole flagged while disabled");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> cur_valid_r)
    else $error("accepted word not held for sequencing");
`endif

endmodule
